[sv/stk_pkg.sv]
// ----------------------------------------------------------------------------
// stk_pkg: shared definitions for the LIFO stack with key removal
// Operation and status codes, the beat layout and the cell control bundle.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 48;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_POP,
        CMD_LOAD,
        CMD_SORT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic               phase;
        logic [DATA_W-1:0]  key;
    } cell_ctrl_t;

endpackage

[sv/stack_with_key_removal.sv]
// ----------------------------------------------------------------------------
// stack_with_key_removal: bounded LIFO of signed 32-bit words
// Push, pop, clear and removal of every entry equal to a key, one result
// beat per operation.
//
// Channel   Dir  Beat contents
// s_*       in   tuser: opcode[1:0]; tdata: operand[31:0]
// m_*       out  tdata: popped_value, status, is_empty, entry_count
//
// Key removal first marks the slots, then runs STACK_DEPTH rounds of odd-even
// exchange along the cell chain, which sink the removed slots below the kept
// entries. Reset clears the entry count and the cell flags; the stored words
// need none. The input stalls during key removal and while a result beat
// waits and m_tready is low.
// ----------------------------------------------------------------------------
module stack_with_key_removal
    import stk_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operand[31:0]
    input  logic [OP_W-1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // popped_value[31:0], status[33:32],
                                        // is_empty[34], entry_count[41:35]
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SORT = 2'b10
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  round_reg;
    logic [CNT_W-1:0]  round_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] data_w [STACK_DEPTH];
    logic              flag_w [STACK_DEPTH];
    logic              mark_w [STACK_DEPTH];

    logic              in_acc;
    logic              full;
    logic              emit;
    logic [DATA_W-1:0] res_popped;
    logic [STATUS_W-1:0] res_status;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        ctrl.cmd       = CMD_HOLD;
        ctrl.phase     = round_reg[0];
        ctrl.key       = s_tdata;
        emit           = 1'b0;
        res_popped     = '0;
        res_status     = STAT_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (s_tuser)
                        OP_PUSH:
                        begin
                            emit = 1'b1;
                            if (full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_PUSH;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.cmd   = CMD_POP;
                                res_popped = data_w[0];
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            ctrl.cmd   = CMD_LOAD;
                            round_next = CNT_W'(STACK_DEPTH - 1);
                            state_next = ST_SORT;
                        end
                        OP_CLEAR:
                        begin
                            emit       = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SORT:
            begin
                ctrl.cmd = CMD_SORT;
                // Each removed entry reaches cell 0 of the mark chain once.
                count_next = count_reg - CNT_W'(mark_w[0]);
                if (round_reg == '0)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    round_next = round_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[31:0]  = res_popped;
            out_data_next[33:32] = res_status;
            out_data_next[34]    = (count_next == '0);
            out_data_next[41:35] = COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Cell 0 is the top of the stack.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] lower_data;
        logic              lower_flag;
        logic [DATA_W-1:0] upper_data;
        logic              upper_flag;
        logic              upper_mark;

        if (i == 0)
        begin : g_top
            assign lower_data = s_tdata;
            assign lower_flag = 1'b0;
        end
        else
        begin : g_mid_lo
            assign lower_data = data_w[i-1];
            assign lower_flag = flag_w[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign upper_data = data_w[i];
            assign upper_flag = 1'b1;
            assign upper_mark = 1'b0;
        end
        else
        begin : g_mid_hi
            assign upper_data = data_w[i+1];
            assign upper_flag = flag_w[i+1];
            assign upper_mark = mark_w[i+1];
        end

        stk_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .lower_data (lower_data),
            .lower_flag (lower_flag),
            .upper_data (upper_data),
            .upper_flag (upper_flag),
            .upper_mark (upper_mark),
            .data       (data_w[i]),
            .flag       (flag_w[i]),
            .mark       (mark_w[i])
        );
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_no_accept_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT) |-> !s_tready)
        else $error("input accepted during key removal");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == OP_POP) && (count_reg != '0))
            |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not lower the entry count by one");

    a_sort_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SORT) && (round_reg == '0)) |=> m_tvalid)
        else $error("key removal finished without a result beat");
`endif

endmodule

[sv/stk_cell.sv]
// ----------------------------------------------------------------------------
// stk_cell: one slot of the stack chain
// Holds one entry. Shifts with its neighbors on push and pop, and during key
// removal takes part in an odd-even exchange that sinks deleted slots.
// ----------------------------------------------------------------------------
module stk_cell
    import stk_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [DATA_W-1:0] lower_data,
    input  logic              lower_flag,
    input  logic [DATA_W-1:0] upper_data,
    input  logic              upper_flag,
    input  logic              upper_mark,
    output logic [DATA_W-1:0] data,
    output logic              flag,
    output logic              mark
);

    localparam logic PARITY = 1'(INDEX % 2);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              flag_reg;
    logic              flag_next;
    logic              mark_reg;
    logic              mark_next;
    logic              hit;
    logic              beyond;

    assign hit    = (data_reg == ctrl.key);
    assign beyond = (count <= CNT_W'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        flag_next = flag_reg;
        mark_next = mark_reg;
        unique case (ctrl.cmd)
            CMD_PUSH:
            begin
                data_next = lower_data;
            end
            CMD_POP:
            begin
                data_next = upper_data;
            end
            CMD_LOAD:
            begin
                // A slot sinks if it is unused or holds the key; only used
                // slots that hold the key count as removals.
                flag_next = beyond | hit;
                mark_next = ~beyond & hit;
            end
            CMD_SORT:
            begin
                mark_next = upper_mark;
                if (ctrl.phase == PARITY)
                begin
                    if (flag_reg && !upper_flag)
                    begin
                        data_next = upper_data;
                        flag_next = 1'b0;
                    end
                end
                else
                begin
                    if (lower_flag && !flag_reg)
                    begin
                        data_next = lower_data;
                        flag_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            mark_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign flag = flag_reg;
    assign mark = mark_reg;

endmodule

[verif/tb_stack_with_key_removal.sv]
// ----------------------------------------------------------------------------
// tb_stack_with_key_removal: self-checking bench for the LIFO with key removal
// Drives push, pop, key removal and clear beats into the stack and tracks its
// contents in a local copy that works out every result beat. A monitor
// compares each result beat field by field with the oldest pending result.
// Directed cases cover the field extremes, the empty and full stack, and
// removal with zero and many matches. A back-pressure stretch stalls
// the input, and random traffic under varying idle rates follows.
// ----------------------------------------------------------------------------
module tb_stack_with_key_removal;
    import stk_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int KEY_POOL_N  = 4;

    typedef struct packed {
        logic [DATA_W-1:0]   popped;
        logic [STATUS_W-1:0] status;
        logic                empty_flag;
        logic [COUNT_W-1:0]  count;
    } stack_result_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]  s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Local copy of the stack contents; index 0 is the bottom.
    logic [DATA_W-1:0] held_words [STACK_DEPTH];
    int                held_count = 0;

    stack_result_t     pending_results [$];
    logic [DATA_W-1:0] key_pool [KEY_POOL_N];

    int error_count  = 0;
    int cycle_count  = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int stall_cycles = 0;

    stack_with_key_removal #(
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Applies one operation to the local stack and returns the result beat.
    function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0] op,
                                                     input logic [DATA_W-1:0] operand);
        stack_result_t res;
        int            kept;
        res  = '0;
        kept = 0;
        res.status = STAT_OK;
        case (op)
            OP_PUSH:
            begin
                if (held_count >= STACK_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    held_words[held_count] = operand;
                    held_count++;
                end
            end
            OP_POP:
            begin
                if (held_count == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    held_count--;
                    res.popped = held_words[held_count];
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_words[i] != operand)
                    begin
                        held_words[kept] = held_words[i];
                        kept++;
                    end
                end
                held_count = kept;
            end
            default:
                held_count = 0;
        endcase
        res.empty_flag = (held_count == 0);
        res.count      = held_count[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Monitor: the prediction for an accepted beat is queued before the
    // result beat of the same edge is checked, so ordering never races.
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_stack_op(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    report_field("popped_value", want.popped, m_tdata[31:0]);
                    report_field("status", DATA_W'(want.status),
                                 DATA_W'(m_tdata[33:32]));
                    report_field("is_empty", DATA_W'(want.empty_flag),
                                 DATA_W'(m_tdata[34]));
                    report_field("entry_count", DATA_W'(want.count),
                                 DATA_W'(m_tdata[41:35]));
                end
            end
        end
    end

    // Result side: random idling, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (stall_cycles > 0)
        begin
            m_tready <= 1'b0;
            stall_cycles--;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] operand);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= operand;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        if (r < 6 && held_count > 0)
            return held_words[$urandom_range(0, held_count - 1)];
        return $urandom;
    endfunction

    task automatic refresh_key_pool();
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom;
        // Now and then one key sits at a signed extreme.
        if ($urandom_range(0, 3) == 0)
            key_pool[0] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endtask

    task automatic test_basic_ops();
        send_op(OP_POP, 32'hDEAD_BEEF);
        send_op(OP_REMOVE, 32'h0000_0000);
        send_op(OP_CLEAR, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_PUSH, 32'h0000_0000);
        send_op(OP_PUSH, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_PUSH, 32'h1234_5678);
        // Two matches in the middle; the rest must keep their order.
        send_op(OP_REMOVE, 32'h7FFF_FFFF);
        send_op(OP_REMOVE, 32'h5555_5555);
        repeat (4)
            send_op(OP_POP, 32'h0000_0000);
        send_op(OP_POP, 32'hAAAA_AAAA);
        send_op(OP_PUSH, 32'h0000_0005);
        send_op(OP_PUSH, 32'h0000_0005);
        send_op(OP_REMOVE, 32'h0000_0005);
        send_op(OP_PUSH, 32'hFFFF_FFFE);
        send_op(OP_CLEAR, 32'h0000_0000);
    endtask

    task automatic test_full_stack();
        refresh_key_pool();
        for (int i = 0; i < STACK_DEPTH; i++)
            send_op(OP_PUSH, key_pool[i % KEY_POOL_N]);
        send_op(OP_PUSH, 32'hCAFE_F00D);
        send_op(OP_REMOVE, key_pool[0]);
        while (held_count < STACK_DEPTH)
            send_op(OP_PUSH, $urandom);
        send_op(OP_PUSH, $urandom);
        send_op(OP_REMOVE, $urandom);
        repeat (3)
            send_op(OP_POP, $urandom);
        send_op(OP_CLEAR, $urandom);
    endtask

    // The result side holds off while pushes keep coming, so the block
    // stalls its input with a result beat waiting.
    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_cycles = 200;
        for (int i = 0; i < 24; i++)
            send_op((i % 5 == 4) ? OP_POP : OP_PUSH, $urandom);
        send_op(OP_REMOVE, pick_operand());
        send_op(OP_CLEAR, $urandom);
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int snk_pct);
        int               fill_bias;
        int               r;
        logic [OP_W-1:0]  op;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        fill_bias    = 50;
        for (int i = 0; i < n_items; i++)
        begin
            // Segments lean toward filling or draining so that both the
            // full and the empty stack are reached often.
            if (i % 60 == 0)
            begin
                refresh_key_pool();
                fill_bias = $urandom_range(0, 1) ? 85 : 25;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_CLEAR;
            else if (r < 14)
                op = OP_REMOVE;
            else if ($urandom_range(0, 99) < fill_bias)
                op = OP_PUSH;
            else
                op = OP_POP;
            send_op(op, pick_operand());
        end
    endtask

    initial
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            held_words[i] = '0;
        refresh_key_pool();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_full_stack();
        test_backpressure();
        test_random(120, 32, 79);
        test_random(120, 79, 32);
        test_random(120, 0, 0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (STACK_DEPTH + 8)
            @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
